FILE: rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centered moving average unit: field
// widths, queue sizing, and the reciprocal table used by the divider.
// ----------------------------------------------------------------------------
package cma_pkg;

	localparam int unsigned SAMPLE_W    = 17;
	localparam int unsigned AVG_W       = SAMPLE_W + 1;
	localparam int unsigned K_W         = 6;
	localparam int unsigned W_W         = K_W + 1;
	localparam int unsigned MAX_RADIUS  = 63;
	localparam int unsigned STORE_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int unsigned PTR_W       = 7;
	localparam int unsigned SUM_W       = 24;
	localparam int unsigned PROD_W      = 2 * SUM_W;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;
	localparam int unsigned QCNT_W = QAW + 1;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [0:0] REG_RADIUS = 1'b0;

	localparam logic [AVG_W-1:0] NEG_ONE = '1;

	// floor(2^24 / w) for w = 2k+1, indexed by k; k = 0 uses 2^24 - 1
	localparam int unsigned RSCALE = 32'd16777216;
	localparam logic [SUM_W-1:0] RECIP [64] = '{
		24'hFFFFFF,        24'(RSCALE / 3),   24'(RSCALE / 5),   24'(RSCALE / 7),
		24'(RSCALE / 9),   24'(RSCALE / 11),  24'(RSCALE / 13),  24'(RSCALE / 15),
		24'(RSCALE / 17),  24'(RSCALE / 19),  24'(RSCALE / 21),  24'(RSCALE / 23),
		24'(RSCALE / 25),  24'(RSCALE / 27),  24'(RSCALE / 29),  24'(RSCALE / 31),
		24'(RSCALE / 33),  24'(RSCALE / 35),  24'(RSCALE / 37),  24'(RSCALE / 39),
		24'(RSCALE / 41),  24'(RSCALE / 43),  24'(RSCALE / 45),  24'(RSCALE / 47),
		24'(RSCALE / 49),  24'(RSCALE / 51),  24'(RSCALE / 53),  24'(RSCALE / 55),
		24'(RSCALE / 57),  24'(RSCALE / 59),  24'(RSCALE / 61),  24'(RSCALE / 63),
		24'(RSCALE / 65),  24'(RSCALE / 67),  24'(RSCALE / 69),  24'(RSCALE / 71),
		24'(RSCALE / 73),  24'(RSCALE / 75),  24'(RSCALE / 77),  24'(RSCALE / 79),
		24'(RSCALE / 81),  24'(RSCALE / 83),  24'(RSCALE / 85),  24'(RSCALE / 87),
		24'(RSCALE / 89),  24'(RSCALE / 91),  24'(RSCALE / 93),  24'(RSCALE / 95),
		24'(RSCALE / 97),  24'(RSCALE / 99),  24'(RSCALE / 101), 24'(RSCALE / 103),
		24'(RSCALE / 105), 24'(RSCALE / 107), 24'(RSCALE / 109), 24'(RSCALE / 111),
		24'(RSCALE / 113), 24'(RSCALE / 115), 24'(RSCALE / 117), 24'(RSCALE / 119),
		24'(RSCALE / 121), 24'(RSCALE / 123), 24'(RSCALE / 125), 24'(RSCALE / 127)
	};

	typedef struct packed {
		logic [K_W-1:0] k;
		logic           restart;
	} ctl_t;

	typedef struct packed {
		logic           has_main;
		logic           main_avg;
		logic [K_W-1:0] pending;
		logic           last;
	} meta_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] old;
		logic                sub;
		meta_t               meta;
	} q_entry_t;

endpackage

FILE: rtl/cma_front.sv
// ----------------------------------------------------------------------------
// cma_front
// Accepts samples, keeps the window store and sequence position, and
// classifies each sample into the results it will cause.
// ----------------------------------------------------------------------------
module cma_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cma_pkg::ctl_t                 ctl,
	input  logic [cma_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          is_last,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic                          q_full,
	output logic                          q_push,
	output cma_pkg::q_entry_t             q_data
);

	logic [cma_pkg::SAMPLE_W-1:0] mem [cma_pkg::STORE_DEPTH];

	logic [cma_pkg::PTR_W-1:0] wp_q;
	logic [cma_pkg::W_W-1:0]   seen_q;

	logic                         s1_v_q;
	logic [cma_pkg::SAMPLE_W-1:0] sample_s1;
	logic [cma_pkg::SAMPLE_W-1:0] old_s1;
	logic                         sub_s1;
	cma_pkg::meta_t               meta_s1;

	logic [cma_pkg::W_W-1:0]   w;
	logic                      acc;
	logic                      sub;
	logic [cma_pkg::W_W-1:0]   seen_new;
	logic [cma_pkg::PTR_W-1:0] wp_inc;
	cma_pkg::meta_t            meta;

	always_comb begin
		w        = {ctl.k, 1'b1};
		acc      = sample_valid && sample_ready;
		sub      = (seen_q == w);
		seen_new = sub ? seen_q : cma_pkg::W_W'(seen_q + 1'b1);
		wp_inc   = (cma_pkg::PTR_W'(wp_q + 1'b1) == cma_pkg::PTR_W'(w)) ? '0
			: cma_pkg::PTR_W'(wp_q + 1'b1);
		meta.has_main = (seen_new >= cma_pkg::W_W'({1'b0, ctl.k} + 1'b1));
		meta.main_avg = (seen_new == w);
		meta.pending  = meta.has_main ? ctl.k : seen_new[cma_pkg::K_W-1:0];
		meta.last     = is_last;
	end

	assign sample_ready = !s1_v_q || !q_full;
	assign q_push       = s1_v_q && !q_full;

	always_comb begin
		q_data.sample = sample_s1;
		q_data.old    = old_s1;
		q_data.sub    = sub_s1;
		q_data.meta   = meta_s1;
	end

	// sequence position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			seen_q <= '0;
		end else if (ctl.restart) begin
			wp_q   <= '0;
			seen_q <= '0;
		end else if (acc) begin
			if (is_last) begin
				wp_q   <= '0;
				seen_q <= '0;
			end else begin
				wp_q   <= wp_inc;
				seen_q <= seen_new;
			end
		end
	end

	// window store, read of the outgoing sample before it is overwritten
	always_ff @(posedge clk) begin
		if (acc) begin
			mem[wp_q] <= sample;
			old_s1    <= mem[wp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1 <= sample;
			sub_s1    <= sub;
			meta_s1   <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
		end else if (q_push) begin
			s1_v_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/cma_fifo.sv
// ----------------------------------------------------------------------------
// cma_fifo
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module cma_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cma_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output cma_pkg::q_entry_t pop_data,
	output logic              empty
);

	cma_pkg::q_entry_t          mem_q [cma_pkg::QDEPTH];
	logic [cma_pkg::QAW-1:0]    wr_q;
	logic [cma_pkg::QAW-1:0]    rd_q;
	logic [cma_pkg::QCNT_W-1:0] cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign full     = (cnt_q == cma_pkg::QCNT_W'(cma_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= cma_pkg::QAW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= cma_pkg::QAW'(rd_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cma_pkg::QCNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= cma_pkg::QCNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/cma_back.sv
// ----------------------------------------------------------------------------
// cma_back
// Keeps the running sum, divides it by the window length through a
// reciprocal multiply with one correction step, and emits the results,
// expanding the flush of pending positions after the last sample.
// ----------------------------------------------------------------------------
module cma_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cma_pkg::ctl_t                       ctl,
	input  logic                                q_empty,
	input  cma_pkg::q_entry_t                   q_data,
	output logic                                q_pop,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cma_pkg::AVG_W-1:0]    average,
	output logic                                is_last_result
);

	logic [cma_pkg::SUM_W-1:0] sum_q;

	logic                      p1_v_q;
	logic                      p2_v_q;
	logic                      p3_v_q;
	logic [cma_pkg::SUM_W-1:0] sum_s1;
	logic [cma_pkg::SUM_W-1:0] sum_s2;
	logic [cma_pkg::SUM_W-1:0] sum_s3;
	cma_pkg::meta_t            meta_s1;
	cma_pkg::meta_t            meta_s2;
	cma_pkg::meta_t            meta_s3;
	logic [cma_pkg::PROD_W-1:0]   prod_s2;
	logic [cma_pkg::SAMPLE_W-1:0] q0_s3;
	logic [cma_pkg::SUM_W-1:0]    qw_s3;

	logic                         o_valid_q;
	logic [cma_pkg::AVG_W-1:0]    o_avg_q;
	logic                         o_last_q;
	logic [cma_pkg::K_W-1:0]      rem_q;
	logic                         item_last_q;

	logic [cma_pkg::W_W-1:0]      w;
	logic                         adv;
	logic [cma_pkg::SUM_W-1:0]    sum_next;
	logic [cma_pkg::SUM_W-1:0]    r;
	logic [cma_pkg::SAMPLE_W-1:0] qfix;
	logic                         produces;
	logic [cma_pkg::AVG_W-1:0]    ld_avg;
	logic [cma_pkg::K_W-1:0]      ld_rem;

	always_comb begin
		w        = {ctl.k, 1'b1};
		adv      = !o_valid_q || (result_ready && rem_q == '0);
		q_pop    = adv && !q_empty;
		sum_next = cma_pkg::SUM_W'(sum_q
			- (q_data.sub ? cma_pkg::SUM_W'(q_data.old) : '0)
			+ cma_pkg::SUM_W'(q_data.sample));
		r        = cma_pkg::SUM_W'(sum_s3 - qw_s3);
		qfix     = (r >= cma_pkg::SUM_W'(w)) ? cma_pkg::SAMPLE_W'(q0_s3 + 1'b1) : q0_s3;
		produces = meta_s3.has_main || meta_s3.last;
		if (meta_s3.has_main) begin
			ld_avg = meta_s3.main_avg ? {1'b0, qfix} : cma_pkg::NEG_ONE;
			ld_rem = meta_s3.last ? meta_s3.pending : '0;
		end else begin
			ld_avg = cma_pkg::NEG_ONE;
			ld_rem = cma_pkg::K_W'(meta_s3.pending - 1'b1);
		end
	end

	// running sum, cleared on a restart and after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.restart) begin
			sum_q <= '0;
		end else if (q_pop) begin
			sum_q <= q_data.meta.last ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_v_q <= 1'b0;
			p2_v_q <= 1'b0;
			p3_v_q <= 1'b0;
		end else if (adv) begin
			p1_v_q <= !q_empty;
			p2_v_q <= p1_v_q;
			p3_v_q <= p2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1  <= sum_next;
			meta_s1 <= q_data.meta;
			prod_s2 <= cma_pkg::PROD_W'(sum_s1) * cma_pkg::PROD_W'(cma_pkg::RECIP[ctl.k]);
			sum_s2  <= sum_s1;
			meta_s2 <= meta_s1;
			q0_s3   <= prod_s2[cma_pkg::SUM_W+cma_pkg::SAMPLE_W-1:cma_pkg::SUM_W];
			qw_s3   <= cma_pkg::SUM_W'(prod_s2[cma_pkg::SUM_W+cma_pkg::SAMPLE_W-1:cma_pkg::SUM_W]
				* cma_pkg::SUM_W'(w));
			sum_s3  <= sum_s2;
			meta_s3 <= meta_s2;
		end
	end

	// output register with flush expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			rem_q     <= '0;
		end else if (o_valid_q && result_ready && rem_q != '0) begin
			rem_q <= cma_pkg::K_W'(rem_q - 1'b1);
		end else if (adv) begin
			o_valid_q <= p3_v_q && produces;
			rem_q     <= ld_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (o_valid_q && result_ready && rem_q != '0) begin
			o_avg_q  <= cma_pkg::NEG_ONE;
			o_last_q <= item_last_q && (rem_q == cma_pkg::K_W'(1));
		end else if (adv) begin
			o_avg_q     <= ld_avg;
			o_last_q    <= meta_s3.last && (ld_rem == '0);
			item_last_q <= meta_s3.last;
		end
	end

	assign result_valid   = o_valid_q;
	assign average        = o_avg_q;
	assign is_last_result = o_last_q;

endmodule

FILE: rtl/centered_moving_average_unit.sv
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered moving average over a stream of unsigned samples, with the
// window half width set through a small register port.
// ----------------------------------------------------------------------------
// A sample transaction is taken every cycle as long as the results flow out:
// a sample that causes at most one result does not hold up the next. A sample
// flagged is_last emits one result per still-pending position, up to radius+1
// results, one per cycle on the result port while result_ready is high, and
// input backs up behind it through a four-entry queue. Between a sample and
// its results lie the store read, queue, running sum, reciprocal multiply,
// correction and output register. Position p is reported when sample p+radius
// arrives, as the truncated window sum divided by 2*radius+1, or as -1 when no
// full window centers on it. Writing radius (register 0, address 0) restarts
// the sequence; write it only while no transaction is in flight. No clearing
// pass runs after reset: stored samples are only used from slots written in
// the current sequence.
// ----------------------------------------------------------------------------
module centered_moving_average_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cma_pkg::ADDR_W-1:0]          paddr,
	input  logic [cma_pkg::DATA_W-1:0]          pwdata,
	output logic [cma_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [cma_pkg::SAMPLE_W-1:0]        sample,
	input  logic                                is_last,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cma_pkg::AVG_W-1:0]    average,
	output logic                                is_last_result
);

	logic [cma_pkg::K_W-1:0] radius_q;
	logic                    reg_sel;
	logic                    wr_en;
	cma_pkg::ctl_t           ctl;

	logic              q_full;
	logic              q_push;
	cma_pkg::q_entry_t q_push_data;
	logic              q_empty;
	logic              q_pop;
	cma_pkg::q_entry_t q_pop_data;

	// register decode: word index sits above the byte offset
	assign reg_sel = (paddr[cma_pkg::ADDR_W-1:2] == cma_pkg::REG_RADIUS);
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? cma_pkg::DATA_W'(radius_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (wr_en && reg_sel) begin
			radius_q <= pwdata[cma_pkg::K_W-1:0];
		end
	end

	// a radius write clears pointer, count and sum in the same edge
	always_comb begin
		ctl.k       = radius_q;
		ctl.restart = wr_en && reg_sel;
	end

	// front: window store and classification of each sample
	cma_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sample       (sample),
		.is_last      (is_last),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_push_data)
	);

	// decoupling queue
	cma_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// back: running sum, divider and result expansion
	cma_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.q_empty        (q_empty),
		.q_data         (q_pop_data),
		.q_pop          (q_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.average        (average),
		.is_last_result (is_last_result)
	);

endmodule

FILE: tb/centered_moving_average_unit_tb.sv
// ----------------------------------------------------------------------------
// centered_moving_average_unit_tb
// Self-checking bench for the centered moving average unit. A directed
// table walks reset behavior, field extremes, short sequences, radius
// masking and mid-sequence restarts. Random phases then sweep the radius
// and stream well-formed sequences with random content. Every result is
// checked against a typed value or a window model kept in the bench.
// ----------------------------------------------------------------------------
module centered_moving_average_unit_tb;
	import cma_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 8;
	// drain time covers the result pipeline plus a four-entry queue
	localparam int DRAIN_CYCLES   = 24;
	localparam int RANDOM_ITEMS   = 450;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int IDLE_PCT       = 14;
	localparam logic [ADDR_W-1:0]   RADIUS_ADDR = ADDR_W'(4 * REG_RADIUS);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = '1;

	typedef struct packed {
		logic [AVG_W-1:0] avg;
		logic             final_flag;
	} avg_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_RADIUS
	} row_kind_e;

	typedef struct packed {
		row_kind_e        kind;
		logic [31:0]      value;
		logic             last;
		logic             typed;
		logic [AVG_W-1:0] avg;
		logic             avg_last;
	} dir_row_t;

	localparam int DIR_ROWS_N = 25;

	// typed averages only where they are obvious; the rest go through the window model
	localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
		// radius 0 after reset: each sample comes straight back
		'{ROW_SAMPLE, 32'd0,          1'b0, 1'b1, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b0, 1'b1, 18'd131071,  1'b0},
		'{ROW_SAMPLE, 32'h15555,      1'b1, 1'b1, 18'h15555,   1'b1},
		// radius 1, a single-sample sequence flushes one -1 marked last
		'{ROW_RADIUS, 32'd1,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b1, 1'b1, NEG_ONE,     1'b1},
		'{ROW_SAMPLE, 32'd10,         1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd20,         1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd30,         1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd40,         1'b1, 1'b0, 18'd0,       1'b0},
		// upper write bits are dropped, radius becomes 2; full-scale window sum
		'{ROW_RADIUS, 32'hFFFF_FFC2,  1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd131071,     1'b1, 1'b0, 18'd0,       1'b0},
		// widest radius, short sequence: every position flushes as -1
		'{ROW_RADIUS, 32'd63,         1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'h0AAAA,      1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'h15555,      1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd0,          1'b1, 1'b0, 18'd0,       1'b0},
		// radius write mid-sequence drops the samples already taken
		'{ROW_RADIUS, 32'd3,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd1,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd2,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_RADIUS, 32'd1,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd5,          1'b0, 1'b0, 18'd0,       1'b0},
		'{ROW_SAMPLE, 32'd6,          1'b1, 1'b0, 18'd0,       1'b0}
	};

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       psel           = 1'b0;
	logic                       penable        = 1'b0;
	logic                       pwrite         = 1'b0;
	logic [ADDR_W-1:0]          paddr          = '0;
	logic [DATA_W-1:0]          pwdata         = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       sample_valid   = 1'b0;
	logic                       sample_ready;
	logic [SAMPLE_W-1:0]        sample         = '0;
	logic                       is_last        = 1'b0;
	logic                       result_valid;
	logic                       result_ready   = 1'b0;
	logic signed [AVG_W-1:0]    average;
	logic                       is_last_result;

	// window model state
	logic [K_W-1:0]      win_radius;
	logic [SAMPLE_W-1:0] win_store [STORE_DEPTH];
	logic [SUM_W-1:0]    win_sum;
	logic [PTR_W-1:0]    win_ptr;
	logic [PTR_W-1:0]    win_count;

	avg_result_t avg_q [$];
	int          mismatches = 0;
	logic        calm       = 1'b0;
	int          taken;
	int          phase;
	int          budget;
	int          seq_len;
	int          seq_n;
	int unsigned k_pick;
	logic [31:0] wr_value;
	logic        broken;

	centered_moving_average_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.is_last       (is_last),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.average       (average),
		.is_last_result(is_last_result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// clear the running window, as a radius write or a final sample does
	function automatic void restart_window();
		win_sum   = '0;
		win_ptr   = '0;
		win_count = '0;
	endfunction

	// take one sample into the window and list the averages it releases
	function automatic void advance_window(input logic [SAMPLE_W-1:0] s, input logic last,
			output avg_result_t res [$]);
		int unsigned k;
		int unsigned w;
		int unsigned ptr;
		int unsigned pending;
		avg_result_t r;
		k   = win_radius;
		w   = 2 * k + 1;
		ptr = win_ptr;
		res = {};
		if (ptr >= w) begin
			ptr = 0;
		end
		// oldest sample falls out once the window is full
		if (win_count >= w) begin
			win_sum -= SUM_W'(win_store[ptr]);
		end
		win_store[ptr] = s;
		win_sum += SUM_W'(s);
		ptr++;
		if (ptr >= w) begin
			ptr = 0;
		end
		win_ptr = PTR_W'(ptr);
		if (win_count < w) begin
			win_count++;
		end
		// position count-k-1 is now centered, with or without a full window
		if (win_count >= k + 1) begin
			r.avg        = (win_count >= w) ? AVG_W'(win_sum / w) : NEG_ONE;
			r.final_flag = 1'b0;
			res.push_back(r);
			pending = k;
		end else begin
			pending = win_count;
		end
		// final sample flushes every position still waiting
		if (last) begin
			r.avg        = NEG_ONE;
			r.final_flag = 1'b0;
			repeat (pending) res.push_back(r);
			if (res.size() > 0) begin
				res[res.size() - 1].final_flag = 1'b1;
			end
			restart_window();
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: pick_sample = '0;
			1: pick_sample = SAMPLE_MAX;
			default: pick_sample = SAMPLE_W'($urandom);
		endcase
	endfunction

	// one sample transaction, with a random idle gap ahead of it
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last,
			input logic typed, input avg_result_t typed_res);
		avg_result_t res [$];
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		is_last      <= last;
		do @(posedge clk); while (!sample_ready);
		advance_window(s, last, res);
		if (typed) begin
			avg_q.push_back(typed_res);
		end else begin
			foreach (res[i]) avg_q.push_back(res[i]);
		end
	endtask

	// radius write once the unit is quiet, then read it back
	task automatic set_radius(input logic [31:0] value);
		sample_valid <= 1'b0;
		while (avg_q.size() != 0) @(posedge clk);
		// samples that release nothing may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RADIUS_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		win_radius = K_W'(value);
		restart_window();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[K_W-1:0] !== win_radius) begin
			$error("radius: expected %0d, actual %0d", win_radius, prdata[K_W-1:0]);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// result side: random back-pressure, and every result transaction checked in order
	always @(posedge clk) begin
		avg_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (avg_q.size() == 0) begin
				$error("average: no result expected, actual %0d", average);
				mismatches++;
			end else begin
				want = avg_q.pop_front();
				if (average !== want.avg) begin
					$error("average: expected %0d, actual %0d",
						$signed(want.avg), average);
					mismatches++;
				end
				if (is_last_result !== want.final_flag) begin
					$error("is_last_result: expected %0d, actual %0d",
						want.final_flag, is_last_result);
					mismatches++;
				end
			end
		end
		result_ready <= arst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		win_radius = '0;
		restart_window();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_RADIUS) begin
				set_radius(DIR_ROWS[i].value);
			end else begin
				send_sample(SAMPLE_W'(DIR_ROWS[i].value), DIR_ROWS[i].last,
					DIR_ROWS[i].typed, '{DIR_ROWS[i].avg, DIR_ROWS[i].avg_last});
			end
		end

		// random phases: widest radius first, then zero, then mostly small radii
		taken = 0;
		phase = 0;
		while (taken < RANDOM_ITEMS) begin
			if (phase == 0) begin
				k_pick = MAX_RADIUS;
			end else if (phase == 1) begin
				k_pick = 0;
			end else if ($urandom_range(0, 2) == 0) begin
				k_pick = $urandom_range(0, MAX_RADIUS);
			end else begin
				k_pick = $urandom_range(0, 5);
			end
			wr_value = 32'(k_pick);
			if ($urandom_range(0, 3) == 0) begin
				wr_value |= $urandom & 32'hFFFF_FFC0;
			end
			set_radius(wr_value);
			budget = (k_pick >= 32) ? 160 : 50;
			seq_n  = 0;
			broken = 1'b0;
			while (seq_n < budget && !broken && taken < RANDOM_ITEMS) begin
				// mostly full windows and a bit more, sometimes a short sequence
				if (phase == 0 && seq_n == 0) begin
					seq_len = 2 * k_pick + 6;
				end else if ($urandom_range(0, 3) == 0) begin
					seq_len = $urandom_range(1, 2 * k_pick + 1);
				end else begin
					seq_len = $urandom_range(2 * k_pick + 1, 2 * k_pick + 13);
				end
				// the closing sequence is trimmed to the item count
				if (seq_len > RANDOM_ITEMS - taken) begin
					seq_len = RANDOM_ITEMS - taken;
				end
				// now and then the sequence is cut off by the next radius write
				broken = ($urandom_range(0, 9) == 0);
				for (int j = 0; j < seq_len; j++) begin
					// a long stretch where neither side idles
					calm = (taken >= 150 && taken < 250);
					send_sample(pick_sample(), !broken && (j == seq_len - 1), 1'b0, '0);
					taken++;
					seq_n++;
				end
			end
			phase++;
		end

		calm = 1'b0;
		sample_valid <= 1'b0;
		while (avg_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Mismatches found");
		$finish;
	end

endmodule
